[rtl/ors_pkg.sv]
// Shared codes and constants for the 1-Wire ROM search engine.
`timescale 1ns / 1ps
package ors_pkg;

   // Input transaction action codes
   localparam logic [1:0] ACT_RESTART = 2'd0;
   localparam logic [1:0] ACT_BEGIN   = 2'd1;
   localparam logic [1:0] ACT_BIT     = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_FOUND        = 3'd1;
   localparam logic [2:0] ST_NO_DEVICE    = 3'd2;
   localparam logic [2:0] ST_NO_PRESENCE  = 3'd3;
   localparam logic [2:0] ST_NOT_SEARCHING = 3'd4;

   // UART reply bytes
   localparam logic [7:0] UART_ONE       = 8'hFF;
   localparam logic [7:0] UART_ZERO      = 8'h00;
   localparam logic [7:0] UART_RESET_TX  = 8'hF0;

   localparam logic [7:0] MARKER_FIRST   = 8'hFF;  // discrepancy before first pass
   localparam logic [7:0] CMD_RESET      = 8'hF0;  // search command after reset

   localparam int unsigned ROM_BYTES = 8;
   localparam int unsigned ROM_WIDTH = 64;

   typedef logic [7:0] rom_byte_type;

endpackage

[rtl/onewire_rom_search_engine.sv]
// Top level of the 1-Wire ROM search decision engine.
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its request transaction is accepted.
// One transaction per cycle unless a stalled result holds the flow; the decision is a single combinational
//   pass from the search state and the request into the result register.
// A stalled result sits in the result register; req_ready stays high as long as
//   that register is empty or is being drained in the same cycle.
// Reset (synchronous, active high): marker 255, idle, ROM store zero, command 0xF0.
module onewire_rom_search_engine #(
   parameter int ROM_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_reset_reply,
   input  logic [7:0]  req_id_reply,
   input  logic [7:0]  req_cpl_reply,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_direction_bit,
   output logic [7:0]  rsp_command_byte,
   output logic [63:0] rsp_rom_id,
   output logic        rsp_pass_done
);

   localparam logic [6:0] RomBitsVal = 7'(ROM_BITS);

   // search command register
   logic [7:0] search_cmd_ff;

   // search state
   logic [7:0] discrepancy_ff,  discrepancy_in;
   logic [6:0] next_disc_ff,    next_disc_in;
   logic [6:0] bits_left_ff,    bits_left_in;
   logic       searching_ff,    searching_in;
   ors_pkg::rom_byte_type rom_store_ff [ors_pkg::ROM_BYTES];
   ors_pkg::rom_byte_type rom_store_in [ors_pkg::ROM_BYTES];

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff,  status_in;
   logic        dir_ff,     dir_in;
   logic [7:0]  cmd_ff,     cmd_in;
   logic [63:0] rom_id_ff,  rom_id_in;
   logic        done_ff,    done_in;

   logic       accept;
   logic [6:0] bit_pos;   // bits consumed so far in this pass
   logic [2:0] byte_idx;
   logic       id_bit, cpl_bit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign bit_pos  = RomBitsVal - bits_left_ff;
   assign byte_idx = bit_pos[5:3];
   assign id_bit   = (req_id_reply  == ors_pkg::UART_ONE);
   assign cpl_bit  = (req_cpl_reply == ors_pkg::UART_ONE);

   // Decision logic: one transaction, one pass
   always_comb begin
      logic take_one;
      discrepancy_in = discrepancy_ff;
      next_disc_in   = next_disc_ff;
      bits_left_in   = bits_left_ff;
      searching_in   = searching_ff;
      rom_store_in   = rom_store_ff;
      status_in      = ors_pkg::ST_NOT_SEARCHING;
      dir_in         = 1'b0;
      cmd_in         = '0;
      done_in        = 1'b0;
      take_one       = id_bit;

      priority if (req_action == ors_pkg::ACT_RESTART) begin
         discrepancy_in = ors_pkg::MARKER_FIRST;
         searching_in   = 1'b0;
         status_in      = ors_pkg::ST_OK;
      end else if (req_action == ors_pkg::ACT_BEGIN) begin
         priority if (discrepancy_ff == '0) begin
            // enumeration finished, re-arm for the next round
            discrepancy_in = ors_pkg::MARKER_FIRST;
            searching_in   = 1'b0;
            status_in      = ors_pkg::ST_NO_DEVICE;
            done_in        = 1'b1;
         end else if (req_reset_reply == ors_pkg::UART_ZERO ||
                      req_reset_reply == ors_pkg::UART_RESET_TX) begin
            // bus echoed the reset pulse unchanged: nobody answered
            searching_in = 1'b0;
            status_in    = ors_pkg::ST_NO_PRESENCE;
            done_in      = 1'b1;
         end else begin
            bits_left_in = RomBitsVal;
            next_disc_in = '0;
            searching_in = 1'b1;
            cmd_in       = search_cmd_ff;
            status_in    = ors_pkg::ST_OK;
         end
      end else if (req_action == ors_pkg::ACT_BIT && searching_ff &&
                   bits_left_ff != '0) begin
         if (id_bit && cpl_bit) begin
            // no device answered this slot
            discrepancy_in = {1'b0, next_disc_ff};
            searching_in   = 1'b0;
            status_in      = ors_pkg::ST_NO_DEVICE;
            done_in        = 1'b1;
         end else begin
            // collision: go 1 below the marker, or repeat a previous 1 off the marker
            if (!id_bit && !cpl_bit) begin
               if ({1'b0, bits_left_ff} < discrepancy_ff ||
                   (rom_store_ff[byte_idx][0] &&
                    discrepancy_ff != {1'b0, bits_left_ff})) begin
                  take_one     = 1'b1;
                  next_disc_in = bits_left_ff;
               end
            end
            dir_in = take_one;
            rom_store_in[byte_idx] = {take_one, rom_store_ff[byte_idx][7:1]};
            bits_left_in = bits_left_ff - 7'd1;
            if (bits_left_ff == 7'd1) begin
               discrepancy_in = {1'b0, next_disc_in};
               searching_in   = 1'b0;
               status_in      = ors_pkg::ST_FOUND;
               done_in        = 1'b1;
            end else begin
               status_in = ors_pkg::ST_OK;
            end
         end
      end else begin
         status_in = ors_pkg::ST_NOT_SEARCHING;
      end

      for (int i = 0; i < ors_pkg::ROM_BYTES; i++) begin
         rom_id_in[i*8 +: 8] = rom_store_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_cmd_ff  <= ors_pkg::CMD_RESET;
         discrepancy_ff <= ors_pkg::MARKER_FIRST;
         next_disc_ff   <= '0;
         bits_left_ff   <= '0;
         searching_ff   <= 1'b0;
         for (int i = 0; i < ors_pkg::ROM_BYTES; i++) begin
            rom_store_ff[i] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            search_cmd_ff <= csr_wr_data;
         end
         if (accept) begin
            discrepancy_ff <= discrepancy_in;
            next_disc_ff   <= next_disc_in;
            bits_left_ff   <= bits_left_in;
            searching_ff   <= searching_in;
            rom_store_ff   <= rom_store_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         dir_ff    <= dir_in;
         cmd_ff    <= cmd_in;
         rom_id_ff <= rom_id_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_direction_bit = dir_ff;
   assign rsp_command_byte  = cmd_ff;
   assign rsp_rom_id        = rom_id_ff;
   assign rsp_pass_done     = done_ff;

endmodule

[rtl/ors_checker.sv]
// Port-level assertions for the ROM search engine, bound to the top level.
`timescale 1ns / 1ps
module ors_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_direction_bit,
   input logic [7:0]  rsp_command_byte,
   input logic        rsp_pass_done
);

   // pass_done goes with exactly the terminal status codes
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass_done == (rsp_status == ors_pkg::ST_FOUND ||
                                       rsp_status == ors_pkg::ST_NO_DEVICE ||
                                       rsp_status == ors_pkg::ST_NO_PRESENCE)))
      else $error("pass_done does not match status");

   // a set direction bit only comes from a completed bit step
   a_dir_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_direction_bit) |->
         (rsp_status == ors_pkg::ST_OK || rsp_status == ors_pkg::ST_FOUND))
      else $error("direction bit on a non-step result");

   // a command byte is only sent when a pass begins
   a_cmd_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_byte != '0) |->
         (rsp_status == ors_pkg::ST_OK && !rsp_pass_done && !rsp_direction_bit))
      else $error("command byte on a non-begin result");

   // an empty result slot never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_pass_done)))
      else $error("stalled result changed");

endmodule

bind onewire_rom_search_engine ors_checker u_ors_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_direction_bit (rsp_direction_bit),
   .rsp_command_byte  (rsp_command_byte),
   .rsp_pass_done     (rsp_pass_done)
);

[dv/testbench.sv]
// Self-checking testbench for the 1-Wire ROM search decision engine.
`timescale 1ns / 1ps
module testbench;

   // One result transaction as the engine should present it.
   typedef struct packed {
      logic [2:0]  status;
      logic        direction;
      logic [7:0]  command;
      logic [63:0] rom;
      logic        done;
   } search_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ors_pkg::ACT_RESTART;
   logic [7:0]  req_reset_reply = 8'h00;
   logic [7:0]  req_id_reply = 8'h00;
   logic [7:0]  req_cpl_reply = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_direction_bit;
   logic [7:0]  rsp_command_byte;
   logic [63:0] rsp_rom_id;
   logic        rsp_pass_done;

   onewire_rom_search_engine dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_reset_reply   (req_reset_reply),
      .req_id_reply      (req_id_reply),
      .req_cpl_reply     (req_cpl_reply),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_direction_bit (rsp_direction_bit),
      .rsp_command_byte  (rsp_command_byte),
      .rsp_rom_id        (rsp_rom_id),
      .rsp_pass_done     (rsp_pass_done)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the engine's search state and its one register.
   logic [7:0] search_cmd;
   logic [7:0] marker;        // discrepancy marker carried between passes
   logic [7:0] next_marker;   // last collision that took the 1 branch this pass
   logic [7:0] bits_left;
   logic       searching;
   logic [7:0] rom_bytes [ors_pkg::ROM_BYTES];

   search_result_type expected_results [$];
   search_result_type rsp_expected;
   int mismatch_count = 0;
   int items_sent = 0;    // request transactions sent so far
   int burst_left = 1;
   int stall_mode = 0;
   int stall_cycle = 0;

   // Apply one request to the shadow state and work out the response it earns.
   task automatic predict_search_step(input logic [1:0] act, input logic [7:0] rst_b,
                                      input logic [7:0] id_b, input logic [7:0] cpl_b,
                                      output search_result_type r);
      logic       b;
      logic       c;
      int         idx;
      logic [7:0] n;
      r = '0;
      r.status = ors_pkg::ST_NOT_SEARCHING;
      case (act)
         ors_pkg::ACT_RESTART: begin
            marker = ors_pkg::MARKER_FIRST;
            searching = 1'b0;
            r.status = ors_pkg::ST_OK;
         end
         ors_pkg::ACT_BEGIN: begin
            if (marker == 8'd0) begin
               // enumeration already finished: re-arm for the first device
               marker = ors_pkg::MARKER_FIRST;
               searching = 1'b0;
               r.status = ors_pkg::ST_NO_DEVICE;
               r.done = 1'b1;
            end else if (rst_b == ors_pkg::UART_ZERO || rst_b == ors_pkg::UART_RESET_TX) begin
               searching = 1'b0;
               r.status = ors_pkg::ST_NO_PRESENCE;
               r.done = 1'b1;
            end else begin
               bits_left = 8'(ors_pkg::ROM_WIDTH);
               next_marker = 8'd0;
               searching = 1'b1;
               r.command = search_cmd;
               r.status = ors_pkg::ST_OK;
            end
         end
         ors_pkg::ACT_BIT: begin
            if (searching && bits_left != 8'd0) begin
               b = (id_b == ors_pkg::UART_ONE);
               c = (cpl_b == ors_pkg::UART_ONE);
               if (b && c) begin
                  // nobody answered: pass aborts, store keeps partial bits
                  marker = next_marker;
                  searching = 1'b0;
                  r.status = ors_pkg::ST_NO_DEVICE;
                  r.done = 1'b1;
               end else begin
                  idx = ((ors_pkg::ROM_WIDTH - int'(bits_left)) >> 3) & 7;
                  n = bits_left;
                  if (!b && !c) begin
                     // collision: go 1 below the marker, or repeat an old 1
                     // anywhere except at the marker itself
                     if (n < marker || (rom_bytes[idx][0] && marker != n)) begin
                        b = 1'b1;
                        next_marker = {1'b0, n[6:0]};
                     end
                  end
                  r.direction = b;
                  rom_bytes[idx] = {b, rom_bytes[idx][7:1]};
                  bits_left = bits_left - 8'd1;
                  if (bits_left == 8'd0) begin
                     marker = next_marker;
                     searching = 1'b0;
                     r.status = ors_pkg::ST_FOUND;
                     r.done = 1'b1;
                  end else begin
                     r.status = ors_pkg::ST_OK;
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < ors_pkg::ROM_BYTES; i++) r.rom[8*i +: 8] = rom_bytes[i];
   endtask

   // Send one request transaction. Valid stays up across a burst; when the burst
   // runs out the sender drops valid and idles for a random gap.
   task automatic send_item(input logic [1:0] act, input logic [7:0] rst_b,
                            input logic [7:0] id_b, input logic [7:0] cpl_b,
                            output search_result_type res);
      req_valid <= 1'b1;
      req_action <= act;
      req_reset_reply <= rst_b;
      req_id_reply <= id_b;
      req_cpl_reply <= cpl_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_search_step(act, rst_b, id_b, cpl_b, res);
      expected_results.push_back(res);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Hold the sender off and wait until every response has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_search_command(input logic [7:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      search_cmd = value;
   endtask

   // Wire reply byte: a 1 always reads back as 0xFF, a 0 as 0x00 or any
   // other non-0xFF byte.
   function automatic logic [7:0] reply_byte(input logic bit_val);
      if (bit_val) return ors_pkg::UART_ONE;
      if ($urandom_range(0, 3) != 0) return ors_pkg::UART_ZERO;
      return 8'($urandom_range(0, 254));
   endfunction

   function automatic logic [7:0] random_reply();
      case ($urandom_range(0, 2))
         0:       return ors_pkg::UART_ONE;
         1:       return ors_pkg::UART_ZERO;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Bit step and unknown action while idle, then both no-presence replies and a restart.
   task automatic test_idle_requests();
      search_result_type res;
      send_item(ors_pkg::ACT_BIT, 8'hFF, ors_pkg::UART_ZERO, ors_pkg::UART_ONE, res);
      send_item(2'd3, 8'h5A, 8'hFF, 8'hFF, res);
      send_item(ors_pkg::ACT_BEGIN, ors_pkg::UART_ZERO, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BEGIN, ors_pkg::UART_RESET_TX, 8'hFF, 8'h00, res);
      send_item(ors_pkg::ACT_RESTART, 8'hFF, 8'hFF, 8'hFF, res);
   endtask

   // Plain bits, collisions (including a near-0xFF byte reading as 0), abort.
   task automatic test_pass_abort();
      search_result_type res;
      send_item(ors_pkg::ACT_BEGIN, 8'h10, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ZERO, ors_pkg::UART_ONE, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ONE, ors_pkg::UART_ZERO, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ZERO, ors_pkg::UART_ZERO, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, 8'hFE, 8'h7F, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ONE, ors_pkg::UART_ONE, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ONE, ors_pkg::UART_ZERO, res);
   endtask

   // A begin in the middle of a pass restarts it; a restart drops it.
   task automatic test_begin_mid_pass();
      search_result_type res;
      send_item(ors_pkg::ACT_BEGIN, 8'hFF, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ZERO, ors_pkg::UART_ZERO, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ONE, ors_pkg::UART_ZERO, res);
      send_item(ors_pkg::ACT_BEGIN, 8'h01, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ZERO, ors_pkg::UART_ZERO, res);
      send_item(ors_pkg::ACT_RESTART, 8'h00, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ZERO, ors_pkg::UART_ONE, res);
   endtask

   // Abort on the first bit leaves the marker at zero, so the next begin
   // reports the enumeration as finished and re-arms.
   task automatic test_marker_zero();
      search_result_type res;
      send_item(ors_pkg::ACT_BEGIN, 8'h55, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BIT, 8'h00, ors_pkg::UART_ONE, ors_pkg::UART_ONE, res);
      send_item(ors_pkg::ACT_BEGIN, 8'h55, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_BEGIN, 8'hEF, 8'h00, 8'h00, res);
      send_item(ors_pkg::ACT_RESTART, 8'h00, 8'h00, 8'h00, res);
   endtask

   // Full enumeration against a modeled bus of devices. Replies follow the
   // wired-AND of the devices still on the chosen branch.
   task automatic run_enumeration(input int n_dev);
      logic [63:0] ids [$];
      logic [63:0] alive [$];
      logic [63:0] keep [$];
      logic [63:0] base;
      logic        any0;
      logic        any1;
      logic [7:0]  rr;
      search_result_type res;
      base = {$urandom, $urandom};
      for (int i = 0; i < n_dev; i++) begin
         // half the devices sit close to a common id for deep branching
         if ($urandom_range(0, 1))
            ids.push_back(base ^ (64'd1 << $urandom_range(0, 63))
                               ^ (64'd1 << $urandom_range(0, 63)));
         else
            ids.push_back({$urandom, $urandom});
      end
      send_item(ors_pkg::ACT_RESTART, random_reply(), random_reply(), random_reply(), res);
      for (int p = 0; p < n_dev + 2; p++) begin
         if (n_dev == 0 && $urandom_range(0, 1))
            rr = $urandom_range(0, 1) ? ors_pkg::UART_ZERO : ors_pkg::UART_RESET_TX;
         else
            do rr = 8'($urandom_range(0, 255));
            while (rr == ors_pkg::UART_ZERO || rr == ors_pkg::UART_RESET_TX);
         send_item(ors_pkg::ACT_BEGIN, rr, random_reply(), random_reply(), res);
         if (res.status != ors_pkg::ST_OK) break;
         alive = ids;
         for (int k = 0; k < ors_pkg::ROM_WIDTH; k++) begin
            any0 = 1'b0;
            any1 = 1'b0;
            foreach (alive[i]) if (alive[i][k]) any1 = 1'b1; else any0 = 1'b1;
            if ($urandom_range(0, 499) == 0)
               send_item(ors_pkg::ACT_BIT, random_reply(), random_reply(), random_reply(),
                         res);
            else
               send_item(ors_pkg::ACT_BIT, random_reply(), reply_byte(!any0),
                         reply_byte(!any1), res);
            keep.delete();
            foreach (alive[i]) if (alive[i][k] == res.direction) keep.push_back(alive[i]);
            alive = keep;
            if (res.done || res.status != ors_pkg::ST_OK) break;
         end
      end
   endtask

   // A pass with arbitrary replies and stray actions mixed in.
   task automatic run_broken_pass();
      search_result_type res;
      logic [1:0] act;
      send_item(ors_pkg::ACT_BEGIN, random_reply(), random_reply(), random_reply(), res);
      repeat ($urandom_range(1, 70)) begin
         act = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : ors_pkg::ACT_BIT;
         if ($urandom_range(0, 19) == 0)
            send_item(act, random_reply(), ors_pkg::UART_ONE, ors_pkg::UART_ONE, res);
         else
            send_item(act, random_reply(), random_reply(), random_reply(), res);
      end
   endtask

   task automatic run_noise();
      search_result_type res;
      repeat ($urandom_range(1, 10))
         send_item(2'($urandom_range(0, 3)), random_reply(), random_reply(), random_reply(),
                   res);
   endtask

   task automatic test_random_search(input int target);
      int pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            run_enumeration(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
         else if (pick < 17)
            run_broken_pass();
         else
            run_noise();
      end
   endtask

   // Response side: compare each accepted transaction with the oldest pending
   // prediction, then pick the next ready value from the current stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d dir %0b cmd %h rom %h done %0b",
                        rsp_status, rsp_direction_bit, rsp_command_byte, rsp_rom_id,
                        rsp_pass_done);
         end else begin
            rsp_expected = expected_results.pop_front();
            if (rsp_status !== rsp_expected.status ||
                rsp_direction_bit !== rsp_expected.direction ||
                rsp_command_byte !== rsp_expected.command ||
                rsp_rom_id !== rsp_expected.rom ||
                rsp_pass_done !== rsp_expected.done) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected status %0d dir %0b cmd %h rom %h done %0b",
                           rsp_expected.status, rsp_expected.direction,
                           rsp_expected.command, rsp_expected.rom, rsp_expected.done);
                  $display("          actual   status %0d dir %0b cmd %h rom %h done %0b",
                           rsp_status, rsp_direction_bit, rsp_command_byte, rsp_rom_id,
                           rsp_pass_done);
               end
            end
         end
      end
      stall_cycle++;
      if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ready <= ((stall_cycle % 6) < 2);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      search_cmd = ors_pkg::CMD_RESET;
      marker = ors_pkg::MARKER_FIRST;
      next_marker = 8'd0;
      bits_left = 8'd0;
      searching = 1'b0;
      foreach (rom_bytes[i]) rom_bytes[i] = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed checks run with the command register at its reset value
      test_idle_requests();
      test_pass_abort();
      test_begin_mid_pass();
      test_marker_zero();

      // random phases, each under a different search command
      write_search_command(8'h00);
      test_random_search(480);
      write_search_command(8'hFF);
      test_random_search(920);
      write_search_command(8'($urandom_range(0, 255)));
      test_random_search(1340);
      write_search_command(ors_pkg::CMD_RESET);
      test_random_search(1750);

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
